[hw/rtl/mma_pkg.sv]
// ----------------------------------------------------------------------------
// mma_pkg
// shared types and constants for the matrix multiply-accumulate engine
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int WORD_W = 32;
  localparam int IDX_W  = 4;
  localparam int OP_W   = 3;
  localparam int SIZE_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = SIZE_W;

  localparam logic [OP_W-1:0] OP_WRITE_A = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE_C = 3'd2;
  localparam logic [OP_W-1:0] OP_COMPUTE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_C  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUMULATE  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_INIT  = 5'b00100,
    S_MAC   = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } mac_ctrl_t;

endpackage

[hw/rtl/mma_mac.sv]
// ----------------------------------------------------------------------------
// mma_mac
// registered multiply followed by a wrapping 32-bit accumulator
// ----------------------------------------------------------------------------
module mma_mac (
  input  logic                      clk,
  input  logic                      rst,
  input  mma_pkg::mac_ctrl_t        ctrl,
  input  logic [mma_pkg::WORD_W-1:0] init_value,
  input  logic [mma_pkg::WORD_W-1:0] a,
  input  logic [mma_pkg::WORD_W-1:0] b,
  output logic [mma_pkg::WORD_W-1:0] acc,
  output logic                      pending
);
  import mma_pkg::*;

  logic [WORD_W-1:0] prod;
  logic              step_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_q <= 1'b0;
    end else begin
      step_q <= ctrl.step;
    end
  end

  // low half of the product only, wraps like the accumulator
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      prod <= a * b;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= init_value;
    end else if (step_q) begin
      acc <= acc + prod;
    end
  end

  assign pending = step_q;

endmodule

[hw/rtl/matrix_multiply_accumulate_top.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_top
// square integer matrix engine: element writes of A, B, C, element reads of C and a
// compute of C = A*B or C += A*B over the top-left n x n corner
// ----------------------------------------------------------------------------
//  channel   signals                                          handshake
//  command   start, opcode, row_index, col_index,             start & !busy
//            element_value
//  result    result_valid, read_value                         one-cycle strobe
//  config    cfg_wen, cfg_index, cfg_wdata                    cfg_wen
//
//  element writes and reads take one beat per cycle while busy is low; a
//  read result appears in the cycle after its beat is taken.
//  a compute holds busy while it runs: one shared multiplier and
//  accumulator, fed one A/B pair per cycle from the stores, plus a C load,
//  a two-stage drain and a write-back per output element.
//  after reset busy stays high while C is cleared.
//  the receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_top #(
  parameter int MAX_N = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [mma_pkg::OP_W-1:0]        opcode,
  input  logic [mma_pkg::IDX_W-1:0]       row_index,
  input  logic [mma_pkg::IDX_W-1:0]       col_index,
  input  logic signed [mma_pkg::WORD_W-1:0] element_value,
  output logic                            result_valid,
  output logic signed [mma_pkg::WORD_W-1:0] read_value,
  input  logic                            cfg_wen,
  input  logic [mma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mma_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mma_pkg::*;

  localparam int CELLS = MAX_N * MAX_N;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = $clog2(MAX_N + 1);

  function automatic logic [AW-1:0] cell_addr(input int unsigned r, input int unsigned c);
    int unsigned lin;
    lin = r * MAX_N + c;
    return lin[AW-1:0];
  endfunction

  logic [WORD_W-1:0] a_mem [CELLS];
  logic [WORD_W-1:0] b_mem [CELLS];
  logic [WORD_W-1:0] c_mem [CELLS];

  state_t            state;
  logic [SIZE_W-1:0] matrix_size;
  logic              accumulate_mode;
  logic [AW-1:0]     clr_addr;
  logic [CW-1:0]     i, j, k;
  logic [CW-1:0]     n_eff, n_last;
  logic              accept, in_range;
  logic [AW-1:0]     item_addr;
  logic [WORD_W-1:0] a_rd, b_rd, c_rd;
  logic              rd_valid;
  logic              rd_inside;
  logic              write_back;
  logic [WORD_W-1:0] acc;
  logic              mac_pending;
  mac_ctrl_t         mac_ctrl;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign in_range = (32'(row_index) < MAX_N) && (32'(col_index) < MAX_N);
  assign item_addr = in_range ? cell_addr(32'(row_index), 32'(col_index)) : '0;

  always_comb begin
    if (matrix_size == '0) begin
      n_eff = CW'(1);
    end else if (32'(matrix_size) > MAX_N) begin
      n_eff = CW'(MAX_N);
    end else begin
      n_eff = CW'(matrix_size);
    end
  end
  assign n_last = n_eff - CW'(1);

  assign write_back = (state == S_DRAIN) && !rd_valid && !mac_pending;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size     <= SIZE_W'(16);
      accumulate_mode <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_MATRIX_SIZE: matrix_size     <= cfg_wdata[SIZE_W-1:0];
        REG_ACCUMULATE:  accumulate_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      i        <= '0;
      j        <= '0;
      k        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && opcode == OP_COMPUTE) begin
            i     <= '0;
            j     <= '0;
            state <= S_INIT;
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == CELLS - 1) begin
            state <= S_IDLE;
          end
        end
        S_INIT: begin
          k     <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          k <= k + CW'(1);
          if (k == n_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (write_back) begin
            if (j == n_last) begin
              j <= '0;
              if (i == n_last) begin
                state <= S_IDLE;
              end else begin
                i     <= i + CW'(1);
                state <= S_INIT;
              end
            end else begin
              j     <= j + CW'(1);
              state <= S_INIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A and B stores
  always_ff @(posedge clk) begin
    if (accept && in_range && opcode == OP_WRITE_A) begin
      a_mem[item_addr] <= element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_range && opcode == OP_WRITE_B) begin
      b_mem[item_addr] <= element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MAC) begin
      a_rd <= a_mem[cell_addr(32'(i), 32'(k))];
      b_rd <= b_mem[cell_addr(32'(k), 32'(j))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == S_MAC);
    end
  end

  // C store: one write port, one read port
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      c_mem[clr_addr] <= '0;
    end else if (write_back) begin
      c_mem[cell_addr(32'(i), 32'(j))] <= acc;
    end else if (accept && in_range && opcode == OP_WRITE_C) begin
      c_mem[item_addr] <= element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_INIT) begin
      c_rd <= c_mem[cell_addr(32'(i), 32'(j))];
    end else if (accept && opcode == OP_READ_C) begin
      c_rd <= c_mem[item_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= accept && (opcode == OP_READ_C);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_READ_C) begin
      rd_inside <= in_range;
    end
  end

  assign read_value = rd_inside ? c_rd : '0;

  assign mac_ctrl.load = (state == S_MAC) && (k == '0);
  assign mac_ctrl.step = rd_valid;

  mma_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (mac_ctrl),
    .init_value (accumulate_mode ? c_rd : '0),
    .a          (a_rd),
    .b          (b_rd),
    .acc        (acc),
    .pending    (mac_pending)
  );

endmodule
